/* design/tsf_pkg.sv */
`default_nettype none

package tsf_pkg;

  localparam int unsigned MaxBurst   = 64;
  localparam int unsigned MaxResults = 5;

  localparam logic [7:0]  ReadFlag        = 8'h80;
  localparam logic [7:0]  FixedBit        = 8'h40;
  localparam logic [15:0] PollTimeoutRst  = 16'd10;
  localparam logic [15:0] ElapsedMax      = 16'hffff;

  typedef enum logic [1:0] {
    KindStart = 2'd0,
    KindRx    = 2'd1,
    KindWrite = 2'd2,
    KindTick  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ActSend    = 3'd0,
    ActClock   = 3'd1,
    ActData    = 3'd2,
    ActDone    = 3'd3,
    ActTimeout = 3'd4,
    ActRefused = 3'd5
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] byte_value;
    logic       chip_select;
  } result_t;

endpackage

`default_nettype wire

/* design/tsf_in_if.sv */
`default_nettype none

interface tsf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        is_read;
  logic [6:0]  length;
  logic [23:0] address;
  logic [7:0]  rx_byte;
  logic [7:0]  write_byte;

  modport source (
    output valid, kind, is_read, length, address, rx_byte, write_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, is_read, length, address, rx_byte, write_byte,
    output ready
  );
endinterface

`default_nettype wire

/* design/tsf_out_if.sv */
`default_nettype none

interface tsf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] byte_value;
  logic       chip_select;
  logic       last;

  modport source (
    output valid, action, byte_value, chip_select, last,
    input  ready
  );
  modport sink (
    input  valid, action, byte_value, chip_select, last,
    output ready
  );
endinterface

`default_nettype wire

/* design/tpm_spi_transaction_framer_core.sv */
`default_nettype none

// path: results are registered in the bundle stage, then the output stage sends one
// result per cycle while ready (an accepted start gives five, others up to two)
// throughput: one event per cycle while output keeps up; the output port moves one
// result per cycle and sets the sustained rate for events with several results
// reset: asynchronous, clears the protocol state, both result stages and restores
// the poll timeout to ten ticks
module tpm_spi_transaction_framer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tsf_in_if.sink           in_ch,
  tsf_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    PhIdle,
    PhPoll,
    PhWrite,
    PhRead
  } phase_e;

  localparam int unsigned NRes = tsf_pkg::MaxResults;

  phase_e      phase_q, phase_d;
  logic        reading_q, reading_d;
  logic [6:0]  left_q, left_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] timeout_q;

  tsf_pkg::result_t res_d [NRes];
  logic [2:0]       cnt_d;

  tsf_pkg::result_t a_res_q [NRes];
  logic [2:0]       a_cnt_q;
  logic             a_valid_q;

  tsf_pkg::result_t b_res_q [NRes];
  logic [2:0]       b_cnt_q;
  logic [2:0]       b_idx_q;
  logic             b_valid_q;

  logic in_xfer, b_last, b_free, a_move;
  logic [6:0]  left_dec;
  logic [15:0] elapsed_inc;
  logic [7:0]  hdr0;

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, timeout_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= tsf_pkg::PollTimeoutRst;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      timeout_q <= pwdata[15:0];
    end
  end

  // output stage handshake
  assign b_last  = (b_idx_q == b_cnt_q - 3'd1);
  assign b_free  = !b_valid_q || (out_ch.ready && b_last);
  assign a_move  = a_valid_q && b_free;
  assign in_ch.ready = !a_valid_q || b_free;
  assign in_xfer = in_ch.valid && in_ch.ready;

  assign left_dec    = (left_q != 7'd0) ? left_q - 7'd1 : left_q;
  assign elapsed_inc = (elapsed_q != tsf_pkg::ElapsedMax) ? elapsed_q + 16'd1 : elapsed_q;
  assign hdr0 = (in_ch.is_read ? tsf_pkg::ReadFlag : 8'h00) | tsf_pkg::FixedBit
              | {2'b00, 6'(in_ch.length - 7'd1)};

  always_comb begin
    phase_d   = phase_q;
    reading_d = reading_q;
    left_d    = left_q;
    elapsed_d = elapsed_q;
    cnt_d     = 3'd0;
    for (int i = 0; i < NRes; i++) begin
      res_d[i] = '{action: tsf_pkg::ActDone, byte_value: 8'h00, chip_select: 1'b0};
    end

    unique case (tsf_pkg::kind_e'(in_ch.kind))
      tsf_pkg::KindStart: begin
        if (phase_q != PhIdle) begin
          res_d[0] = '{action: tsf_pkg::ActRefused, byte_value: 8'h00, chip_select: 1'b1};
          cnt_d    = 3'd1;
        end else if (in_ch.length == 7'd0 || in_ch.length > 7'(tsf_pkg::MaxBurst)) begin
          res_d[0] = '{action: tsf_pkg::ActRefused, byte_value: 8'h00, chip_select: 1'b0};
          cnt_d    = 3'd1;
        end else begin
          res_d[0] = '{action: tsf_pkg::ActSend, byte_value: hdr0, chip_select: 1'b1};
          res_d[1] = '{action: tsf_pkg::ActSend, byte_value: in_ch.address[23:16],
                       chip_select: 1'b1};
          res_d[2] = '{action: tsf_pkg::ActSend, byte_value: in_ch.address[15:8],
                       chip_select: 1'b1};
          res_d[3] = '{action: tsf_pkg::ActSend, byte_value: in_ch.address[7:0],
                       chip_select: 1'b1};
          res_d[4] = '{action: tsf_pkg::ActClock, byte_value: 8'h00, chip_select: 1'b1};
          cnt_d     = 3'd5;
          phase_d   = PhPoll;
          reading_d = in_ch.is_read;
          left_d    = in_ch.length;
          elapsed_d = 16'd0;
        end
      end
      tsf_pkg::KindRx: begin
        if (phase_q == PhPoll) begin
          if (!in_ch.rx_byte[0]) begin
            res_d[0] = '{action: tsf_pkg::ActClock, byte_value: 8'h00, chip_select: 1'b1};
            cnt_d    = 3'd1;
          end else if (reading_q) begin
            res_d[0] = '{action: tsf_pkg::ActClock, byte_value: 8'h00, chip_select: 1'b1};
            cnt_d    = 3'd1;
            phase_d  = PhRead;
          end else begin
            phase_d  = PhWrite;
          end
        end else if (phase_q == PhRead) begin
          left_d = left_dec;
          if (left_dec == 7'd0) begin
            res_d[0] = '{action: tsf_pkg::ActData, byte_value: in_ch.rx_byte,
                         chip_select: 1'b0};
            res_d[1] = '{action: tsf_pkg::ActDone, byte_value: 8'h00, chip_select: 1'b0};
            phase_d  = PhIdle;
          end else begin
            res_d[0] = '{action: tsf_pkg::ActData, byte_value: in_ch.rx_byte,
                         chip_select: 1'b1};
            res_d[1] = '{action: tsf_pkg::ActClock, byte_value: 8'h00, chip_select: 1'b1};
          end
          cnt_d = 3'd2;
        end
      end
      tsf_pkg::KindWrite: begin
        if (phase_q == PhWrite) begin
          res_d[0] = '{action: tsf_pkg::ActSend, byte_value: in_ch.write_byte,
                       chip_select: 1'b1};
          cnt_d    = 3'd1;
          left_d   = left_dec;
          if (left_dec == 7'd0) begin
            res_d[1] = '{action: tsf_pkg::ActDone, byte_value: 8'h00, chip_select: 1'b0};
            cnt_d    = 3'd2;
            phase_d  = PhIdle;
          end
        end
      end
      tsf_pkg::KindTick: begin
        if (phase_q == PhPoll) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= timeout_q) begin
            res_d[0] = '{action: tsf_pkg::ActTimeout, byte_value: 8'h00, chip_select: 1'b0};
            cnt_d    = 3'd1;
            phase_d  = PhIdle;
            left_d   = 7'd0;
          end
        end
      end
      default: ;
    endcase
  end

  // protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      reading_q <= 1'b0;
      left_q    <= 7'd0;
      elapsed_q <= 16'd0;
    end else if (in_xfer) begin
      phase_q   <= phase_d;
      reading_q <= reading_d;
      left_q    <= left_d;
      elapsed_q <= elapsed_d;
    end
  end

  // result bundle of the newest event, waits for the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_xfer && cnt_d != 3'd0) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && cnt_d != 3'd0) begin
      a_res_q <= res_d;
      a_cnt_q <= cnt_d;
    end
  end

  // output stage, drains one result per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_idx_q   <= 3'd0;
    end else if (a_move) begin
      b_valid_q <= 1'b1;
      b_idx_q   <= 3'd0;
    end else if (b_valid_q && out_ch.ready) begin
      if (b_last) begin
        b_valid_q <= 1'b0;
        b_idx_q   <= 3'd0;
      end else begin
        b_idx_q   <= b_idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_res_q <= a_res_q;
      b_cnt_q <= a_cnt_q;
    end
  end

  assign out_ch.valid       = b_valid_q;
  assign out_ch.action      = b_res_q[b_idx_q].action;
  assign out_ch.byte_value  = b_res_q[b_idx_q].byte_value;
  assign out_ch.chip_select = b_res_q[b_idx_q].chip_select;
  assign out_ch.last        = b_last;

endmodule

`default_nettype wire
